FILE: rtl/core/cbez_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier package
// Shared types, widths and mode codes for the curve evaluator and trimmer.
// ----------------------------------------------------------------------------
package cbez_pkg;

    // Storage width of a control coordinate.
    localparam int COORD_WIDTH = 32;
    localparam int T_W         = 17;
    localparam logic [T_W-1:0] T_ONE = 17'd65536;

    // Item mode codes.
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_EVAL   = 2'd1,
        MODE_TRIM_S = 2'd2,
        MODE_TRIM_E = 2'd3
    } t_mode;

    // One input item.
    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [T_W-1:0]     param_t;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_out_item;

    // Command passed from the front end to the back end.
    typedef struct packed {
        t_mode                     mode;
        logic [1:0]                point_index;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic [T_W-1:0]            param_t;
    } t_cmd;

endpackage : cbez_pkg
`default_nettype wire

FILE: rtl/core/cbez_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier front end
// Accepts items, clamps t, sizes coordinates and queues commands (depth 2).
// ----------------------------------------------------------------------------
module cbez_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  cbez_pkg::t_in_item     i_item,
    output logic                   o_full,
    output logic                   o_cmd_valid,
    output cbez_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_take
);

    cbez_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt, n_cnt;
    cbez_pkg::t_cmd w_cmd;
    logic           w_wr, w_rd;

    // Classify the item: clamp t and size the coordinates.
    always_comb begin
        w_cmd.mode        = cbez_pkg::t_mode'(i_item.mode);
        w_cmd.point_index = i_item.point_index;
        w_cmd.coord_x     = cbez_pkg::COORD_WIDTH'(i_item.coord_x);
        w_cmd.coord_y     = cbez_pkg::COORD_WIDTH'(i_item.coord_y);
        w_cmd.param_t     = (i_item.param_t > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE
                                                               : i_item.param_t;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    // Queue occupancy.
    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= w_cmd;
    end

endmodule : cbez_front
`default_nettype wire

FILE: rtl/core/cbez_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier back end
// Holds the control points and runs evaluation and trims; weights and trim lerps share
// one multiplier, and a state-machine sequencer steps them. Results go to a 2-deep queue.
// ----------------------------------------------------------------------------
module cbez_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  cbez_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_take,
    output logic                   o_empty,
    output cbez_pkg::t_out_item    o_item,
    input  wire logic              i_pop
);

    localparam int CW = cbez_pkg::COORD_WIDTH;
    localparam int AW = CW + 20;  // accumulator width, weights sum below 4.0

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WGT  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                r_st;
    cbez_pkg::t_mode       r_mode;
    logic [16:0]           r_t, r_s;
    logic [4:0]            r_step;
    logic signed [CW-1:0]  r_cx [4];
    logic signed [CW-1:0]  r_cy [4];
    logic [17:0]           r_w [4];
    logic [17:0]           r_s2, r_t2;
    logic signed [AW-1:0]  r_acc_hi;
    logic [AW-1:0]         r_acc_lo;
    logic                  r_axis;
    cbez_pkg::t_out_item   r_oq [2];
    logic                  r_owp, r_orp;
    logic [1:0]            r_ocnt;

    // Shared multiplier for weights and trim lerps: signed CW+1 operand by 19-bit unsigned.
    logic signed [CW:0]    w_ma;
    logic [18:0]           w_mb;
    logic signed [CW+20:0] w_mp;
    assign w_mp = w_ma * $signed({1'b0, w_mb});

    logic       w_pop, w_opush, w_oful;
    assign w_oful  = (r_ocnt == 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_item  = r_oq[r_orp];
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd_take = (r_st == ST_IDLE) && i_cmd_valid;

    // Trim lerp schedule: destination and the pair a, b for each of 6 steps.
    logic [1:0] w_a, w_b;
    always_comb begin
        w_a = 2'd0;
        w_b = 2'd1;
        if (r_mode == cbez_pkg::MODE_TRIM_S) begin
            case (r_step[2:0])
                3'd0, 3'd3, 3'd5: begin w_a = 2'd0; w_b = 2'd1; end
                3'd1, 3'd4:       begin w_a = 2'd1; w_b = 2'd2; end
                default:          begin w_a = 2'd2; w_b = 2'd3; end
            endcase
        end else begin
            case (r_step[2:0])
                3'd0, 3'd3, 3'd5: begin w_a = 2'd2; w_b = 2'd3; end
                3'd1, 3'd4:       begin w_a = 2'd1; w_b = 2'd2; end
                default:          begin w_a = 2'd0; w_b = 2'd1; end
            endcase
        end
    end
    logic [1:0] w_dst;
    assign w_dst = (r_mode == cbez_pkg::MODE_TRIM_S) ? w_a : w_b;

    logic signed [CW-1:0] w_pa, w_pb;
    assign w_pa = r_axis ? r_cy[w_a] : r_cx[w_a];
    assign w_pb = r_axis ? r_cy[w_b] : r_cx[w_b];

    // Current control coordinate for evaluation.
    logic signed [CW-1:0] w_ce;
    assign w_ce = r_axis ? r_cy[r_step[1:0]] : r_cx[r_step[1:0]];

    // Multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            ST_WGT: begin
                case (r_step[2:0])
                    3'd0: begin w_ma = (CW+1)'($signed({1'b0, r_s})); w_mb = 19'(r_s); end
                    3'd1: begin w_ma = (CW+1)'($signed({1'b0, r_t})); w_mb = 19'(r_t); end
                    3'd2: begin w_ma = (CW+1)'($signed({1'b0, r_s})); w_mb = 19'(r_s2); end
                    3'd3: begin
                        w_ma = (CW+1)'($signed({1'b0, r_t}));
                        w_mb = 19'(r_s2) + 19'({r_s2, 1'b0});
                    end
                    3'd4: begin
                        w_ma = (CW+1)'($signed({1'b0, r_s}));
                        w_mb = 19'(r_t2) + 19'({r_t2, 1'b0});
                    end
                    default: begin w_ma = (CW+1)'($signed({1'b0, r_t})); w_mb = 19'(r_t2); end
                endcase
            end
            ST_RUN: begin
                if (r_mode == cbez_pkg::MODE_EVAL) begin
                    // Coordinate against its weight; the accumulator below forms its own
                    // high and low part products.
                    w_ma = (CW+1)'(w_ce);
                    w_mb = 19'(r_w[r_step[1:0]]);
                end else begin
                    w_ma = (CW+1)'(w_pb) - (CW+1)'(w_pa);
                    w_mb = 19'(r_t);
                end
            end
            default: ;
        endcase
    end

    // Rounded Q16 product for weights and lerps (floor shift equals split form).
    logic [CW+4:0] w_rnd;
    assign w_rnd = (CW+5)'((w_mp + (CW+21)'(32768)) >>> 16);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_step <= '0;
            r_axis <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_mode <= i_cmd.mode;
                        r_t    <= i_cmd.param_t;
                        r_s    <= cbez_pkg::T_ONE - i_cmd.param_t;
                        r_step <= '0;
                        r_axis <= 1'b0;
                        r_acc_hi <= '0;
                        r_acc_lo <= '0;
                        case (i_cmd.mode)
                            cbez_pkg::MODE_LOAD: begin
                                r_cx[i_cmd.point_index] <= i_cmd.coord_x;
                                r_cy[i_cmd.point_index] <= i_cmd.coord_y;
                            end
                            cbez_pkg::MODE_EVAL: r_st <= ST_WGT;
                            default: r_st <= ST_RUN;
                        endcase
                    end
                end
                ST_WGT: begin
                    case (r_step[2:0])
                        3'd0: r_s2 <= 18'(w_rnd);
                        3'd1: r_t2 <= 18'(w_rnd);
                        3'd2: r_w[0] <= 18'(w_rnd);
                        3'd3: r_w[1] <= 18'(w_rnd);
                        3'd4: r_w[2] <= 18'(w_rnd);
                        default: r_w[3] <= 18'(w_rnd);
                    endcase
                    if (r_step == 5'd5) begin
                        r_step <= '0;
                        r_st   <= ST_RUN;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                ST_RUN: begin
                    if (r_mode == cbez_pkg::MODE_EVAL) begin
                        // Accumulate hi and lo parts separately, as specified.
                        r_acc_hi <= r_acc_hi + AW'(($signed(w_ce) >>> 16)
                                    * $signed({1'b0, r_w[r_step[1:0]]}));
                        r_acc_lo <= r_acc_lo + AW'(w_ce[15:0] * r_w[r_step[1:0]]);
                        if (r_step[1:0] == 2'd3) begin
                            r_st <= ST_OUT;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end else begin
                        if (r_axis) r_cy[w_dst] <= w_pa + CW'(w_rnd);
                        else        r_cx[w_dst] <= w_pa + CW'(w_rnd);
                        if (r_step == 5'd5) begin
                            r_step <= '0;
                            if (r_axis) r_st <= ST_IDLE;
                            r_axis <= ~r_axis;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                ST_OUT: begin
                    if (r_axis || !w_oful) begin
                        r_acc_hi <= '0;
                        r_acc_lo <= '0;
                        r_step   <= '0;
                        if (r_axis) begin
                            r_axis <= 1'b0;
                            r_st   <= ST_IDLE;
                        end else begin
                            r_axis <= 1'b1;
                            r_st   <= ST_RUN;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Final rounding and saturation of one coordinate.
    logic signed [AW:0]   w_sum;
    logic signed [CW-1:0] w_sat;
    localparam logic signed [AW:0] SAT_HI = (AW+1)'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [AW:0] SAT_LO = -SAT_HI - 1;
    assign w_sum = (AW+1)'(r_acc_hi) + (AW+1)'($signed({1'b0, (r_acc_lo + AW'(32768)) >> 16}));
    assign w_sat = (w_sum > SAT_HI) ? SAT_HI[CW-1:0] :
                   (w_sum < SAT_LO) ? SAT_LO[CW-1:0] : w_sum[CW-1:0];

    logic signed [CW-1:0] r_xres;
    assign w_opush = (r_st == ST_OUT) && r_axis;

    // Hold x while y is accumulated; push both together.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT && !r_axis && !w_oful) r_xres <= w_sat;
        if (w_opush) begin
            r_oq[r_owp].point_x <= 32'(r_xres);
            r_oq[r_owp].point_y <= 32'(w_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) r_owp <= ~r_owp;
            if (w_pop)   r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_pop};
        end
    end

endmodule : cbez_back
`default_nettype wire

FILE: rtl/core/cubic_bezier_eval_trim.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator and trimmer, top level
// Use: items enter through a queue-like port (i_push / o_full). A load writes
// one control point; an evaluate produces one point; a trim rewrites the
// curve as its piece over [t,1] (mode 2) or [0,t] (mode 3).
// Results leave through o_empty / i_pop, oldest first; o_item is valid while
// o_empty is low.
// Timing: the back end works on one command at a time. It takes a command in
// its idle state, which is all a load needs. A trim then runs six lerps per
// axis on the shared multiplier. An evaluate runs six weight products, then
// per axis four multiply-accumulates and one rounding step. A result passes
// through the command queue, the back end and the result queue registers.
// No new command is taken until the current one has finished.
// A two-entry command queue sits between front and back end, and a
// two-entry result queue after the back end, so either side can stall.
// If results are not popped, the back end waits once the result queue is
// full, and o_full rises once the command queue fills.
// Reset clears all control points to zero and empties both queues.
// ----------------------------------------------------------------------------
module cubic_bezier_eval_trim (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  cbez_pkg::t_in_item     i_item,
    output logic                   o_full,
    output logic                   o_empty,
    output cbez_pkg::t_out_item    o_item,
    input  wire logic              i_pop
);

    logic           w_cvalid, w_ctake;
    cbez_pkg::t_cmd w_cmd;

    cbez_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_cmd_valid (w_cvalid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_ctake)
    );

    cbez_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cvalid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_ctake),
        .o_empty     (o_empty),
        .o_item      (o_item),
        .i_pop       (i_pop)
    );

endmodule : cubic_bezier_eval_trim
`default_nettype wire

FILE: rtl/core/cbez_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier port checker
// Watches the top-level ports for ordering and stall behavior.
// ----------------------------------------------------------------------------
module cbez_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_push,
    input wire logic                o_full,
    input wire logic                o_empty,
    input wire logic                i_pop,
    input cbez_pkg::t_out_item      o_item
);

    // A waiting result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_item)))
        else $error("result changed while stalled");

    // Out of reset both queues are empty.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    // A result leaves only through a transfer.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_empty) |-> $past(i_pop))
        else $error("result dropped without a pop");

    // Input side never fills without any transfer in progress.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push))
        else $error("full without a push");

endmodule : cbez_checker

bind cubic_bezier_eval_trim cbez_checker u_cbez_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_item  (o_item)
);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator and trimmer testbench
// Loads control points and evaluates or trims the curve through the queue
// port. Each evaluated point is checked against a fixed-point curve model
// kept in this file. A table of directed items comes first, then random items.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM    = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_TABLE     = 22;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_push = 1'b0;
    cbez_pkg::t_in_item  i_item = '0;
    logic                o_full;
    logic                o_empty;
    cbez_pkg::t_out_item o_item;
    logic                i_pop = 1'b0;

    // Curve control points as the model sees them.
    longint    curve_x [4];
    longint    curve_y [4];
    cbez_pkg::t_out_item point_queue[$];
    int        error_count = 0;
    int        point_count = 0;
    int        trim_count = 0;
    int        cycle_count = 0;
    bit        stall_free = 1'b0;
    bit        hold_done = 1'b0;
    int        sent_count = 0;

    // Directed stimulus table; has_known marks a typed-in expected point.
    typedef struct {
        cbez_pkg::t_in_item  item;
        bit                  has_known;
        cbez_pkg::t_out_item known;
    } t_row;
    t_row table_rows [N_TABLE];

    cubic_bezier_eval_trim u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_item (i_item),
        .o_full (o_full),
        .o_empty(o_empty),
        .o_item (o_item),
        .i_pop  (i_pop)
    );

    always #10 i_clk = ~i_clk;

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Interpolate a toward b by t, rounding halves up.
    function automatic longint interpolate(longint a, longint b, longint t);
        longint diff;
        longint dh;
        longint dl;
        diff = b - a;
        dl = diff & 64'hFFFF;
        dh = (diff - dl) / 65536;
        return a + dh * t + ((dl * t + 32768) >>> 16);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint curve_point(longint c [4], longint w [4]);
        longint sum_hi;
        longint sum_lo;
        longint lo;
        sum_hi = 0;
        sum_lo = 0;
        for (int i = 0; i < 4; i++) begin
            lo = c[i] & 64'hFFFF;
            sum_hi += ((c[i] - lo) / 65536) * w[i];
            sum_lo += lo * w[i];
        end
        return clamp_coord(sum_hi + ((sum_lo + 32768) >>> 16));
    endfunction

    // Cut the curve at t, keeping [t,1] or [0,t].
    task automatic cut_curve(inout longint p [4], input bit keep_start, input longint t);
        if (keep_start) begin
            p[0] = interpolate(p[0], p[1], t);
            p[1] = interpolate(p[1], p[2], t);
            p[2] = interpolate(p[2], p[3], t);
            p[0] = interpolate(p[0], p[1], t);
            p[1] = interpolate(p[1], p[2], t);
            p[0] = interpolate(p[0], p[1], t);
        end else begin
            p[3] = interpolate(p[2], p[3], t);
            p[2] = interpolate(p[1], p[2], t);
            p[1] = interpolate(p[0], p[1], t);
            p[3] = interpolate(p[2], p[3], t);
            p[2] = interpolate(p[1], p[2], t);
            p[3] = interpolate(p[2], p[3], t);
        end
    endtask

    // Apply one accepted item to the model and queue any expected point.
    task automatic apply_curve_item(cbez_pkg::t_in_item it);
        longint t;
        longint s;
        longint s2;
        longint t2;
        longint w [4];
        cbez_pkg::t_out_item pt;
        t = (it.param_t > 17'd65536) ? 65536 : longint'(it.param_t);
        s = 65536 - t;
        case (cbez_pkg::t_mode'(it.mode))
            cbez_pkg::MODE_LOAD: begin
                curve_x[it.point_index] = longint'(it.coord_x);
                curve_y[it.point_index] = longint'(it.coord_y);
            end
            cbez_pkg::MODE_TRIM_S: begin
                cut_curve(curve_x, 1'b1, t);
                cut_curve(curve_y, 1'b1, t);
                trim_count++;
            end
            cbez_pkg::MODE_TRIM_E: begin
                cut_curve(curve_x, 1'b0, t);
                cut_curve(curve_y, 1'b0, t);
                trim_count++;
            end
            default: begin
                s2 = (s * s + 32768) >>> 16;
                t2 = (t * t + 32768) >>> 16;
                w[0] = (s * s2 + 32768) >>> 16;
                w[1] = (3 * s2 * t + 32768) >>> 16;
                w[2] = (3 * s * t2 + 32768) >>> 16;
                w[3] = (t * t2 + 32768) >>> 16;
                pt.point_x = 32'(curve_point(curve_x, w));
                pt.point_y = 32'(curve_point(curve_y, w));
                point_queue.push_back(pt);
            end
        endcase
    endtask

    function automatic cbez_pkg::t_in_item make_item(cbez_pkg::t_mode m, int idx,
                                                     int x, int y, int t);
        cbez_pkg::t_in_item it;
        it.mode = m;
        it.point_index = idx[1:0];
        it.coord_x = x;
        it.coord_y = y;
        it.param_t = t[16:0];
        return it;
    endfunction

    // Offer one item and wait for its transfer; push stays high for the next.
    task automatic push_item(cbez_pkg::t_in_item it);
        int gap;
        if (!stall_free && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        apply_curve_item(it);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Random item: mostly well formed loads, evaluations and trims.
    function automatic cbez_pkg::t_in_item random_item();
        int sel;
        int t;
        int x;
        int y;
        sel = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: t = 0;
            1: t = 65536;
            2: t = $urandom_range(65537, 131071);
            default: t = $urandom_range(0, 65536);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            x = $urandom;
            y = $urandom;
        end else begin
            x = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            y = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        end
        if (sel < 3) return make_item(cbez_pkg::MODE_LOAD, $urandom_range(0, 3), x, y, $urandom);
        if (sel < 7) return make_item(cbez_pkg::MODE_EVAL, $urandom_range(0, 3), x, y, t);
        if (sel < 8) return make_item(cbez_pkg::MODE_TRIM_S, $urandom_range(0, 3), x, y, t);
        return make_item(cbez_pkg::MODE_TRIM_E, $urandom_range(0, 3), x, y, t);
    endfunction

    // Result side: pop with random stalls and one long hold-off.
    initial begin
        int gap;
        cbez_pkg::t_out_item exp_pt;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count > 40) begin
                hold_done = 1'b1;
                i_pop <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (!stall_free && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 14);
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            if (!o_empty) begin
                point_count++;
                if (point_queue.size() == 0) begin
                    $error("point with no expectation: x=%0d y=%0d",
                           o_item.point_x, o_item.point_y);
                    error_count++;
                end else begin
                    exp_pt = point_queue.pop_front();
                    if (o_item.point_x !== exp_pt.point_x) begin
                        $error("point_x expected %0d actual %0d",
                               exp_pt.point_x, o_item.point_x);
                        error_count++;
                    end
                    if (o_item.point_y !== exp_pt.point_y) begin
                        $error("point_y expected %0d actual %0d",
                               exp_pt.point_y, o_item.point_y);
                        error_count++;
                    end
                end
            end
        end
    end

    // Check that a typed-in point is what the model expects too.
    task automatic check_known(cbez_pkg::t_out_item k);
        cbez_pkg::t_out_item last;
        last = point_queue[$];
        if (last !== k) begin
            $error("table point expected x=%0d y=%0d model x=%0d y=%0d",
                   k.point_x, k.point_y, last.point_x, last.point_y);
            error_count++;
        end
    endtask

    // Main sequence.
    initial begin
        for (int i = 0; i < 4; i++) begin
            curve_x[i] = 0;
            curve_y[i] = 0;
        end
        // Evaluate after reset: the curve sits at the origin.
        table_rows[0]  = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 32768), 1'b1, '0};
        table_rows[1]  = '{make_item(cbez_pkg::MODE_LOAD, 0, 32'sh7FFF_FFFF,
                                     32'sh8000_0000, 0), 1'b0, '0};
        // Extremes in all points, evaluated at both ends.
        table_rows[2]  = '{make_item(cbez_pkg::MODE_LOAD, 1, 32'sh7FFF_FFFF,
                                     32'sh8000_0000, 0), 1'b0, '0};
        table_rows[3]  = '{make_item(cbez_pkg::MODE_LOAD, 2, 32'sh7FFF_FFFF,
                                     32'sh8000_0000, 0), 1'b0, '0};
        table_rows[4]  = '{make_item(cbez_pkg::MODE_LOAD, 3, 32'sh7FFF_FFFF,
                                     32'sh8000_0000, 0), 1'b0, '0};
        table_rows[5]  = '{make_item(cbez_pkg::MODE_EVAL, 3, 0, 0, 0), 1'b1,
                           '{32'sh7FFF_FFFF, 32'sh8000_0000}};
        table_rows[6]  = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 65536), 1'b1,
                           '{32'sh7FFF_FFFF, 32'sh8000_0000}};
        // Weight rounding may push above one; saturation holds the range.
        table_rows[7]  = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 21845), 1'b0, '0};
        // Clamped t above one.
        table_rows[8]  = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 131071), 1'b1,
                           '{32'sh7FFF_FFFF, 32'sh8000_0000}};
        table_rows[9]  = '{make_item(cbez_pkg::MODE_LOAD, 0, 0, 0, 0), 1'b0, '0};
        table_rows[10] = '{make_item(cbez_pkg::MODE_LOAD, 1, 32'sh0001_0000,
                                     -32'sh0001_0000, 0), 1'b0, '0};
        table_rows[11] = '{make_item(cbez_pkg::MODE_LOAD, 2, 32'sh0003_0000,
                                     32'sh0002_0000, 0), 1'b0, '0};
        table_rows[12] = '{make_item(cbez_pkg::MODE_LOAD, 3, -32'sh0004_0000,
                                     32'sh0005_8000, 0), 1'b0, '0};
        table_rows[13] = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 32768), 1'b0, '0};
        table_rows[14] = '{make_item(cbez_pkg::MODE_TRIM_S, 0, 0, 0, 16384), 1'b0, '0};
        table_rows[15] = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 40000), 1'b0, '0};
        table_rows[16] = '{make_item(cbez_pkg::MODE_TRIM_E, 0, 0, 0, 50000), 1'b0, '0};
        table_rows[17] = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 12345), 1'b0, '0};
        // Trims at the ends collapse the curve to an end point.
        table_rows[18] = '{make_item(cbez_pkg::MODE_TRIM_E, 0, 0, 0, 0), 1'b0, '0};
        table_rows[19] = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 65536), 1'b0, '0};
        table_rows[20] = '{make_item(cbez_pkg::MODE_TRIM_S, 0, 0, 0, 131071), 1'b0, '0};
        table_rows[21] = '{make_item(cbez_pkg::MODE_EVAL, 0, 0, 0, 30000), 1'b0, '0};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_TABLE; r++) begin
            push_item(table_rows[r].item);
            if (table_rows[r].has_known) check_known(table_rows[r].known);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 80) stall_free = 1'b1;
            push_item(random_item());
        end
        i_push <= 1'b0;

        // Drain, then allow the back end to finish any trailing trim.
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Run covered %0d items, %0d points checked, %0d trims.",
                 sent_count, point_count, trim_count);
        if (error_count == 0 && point_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
